FILE: rtl/direct_mapped_cache_tags_assert.svh
// Assertion shorthands for the cache tag controller checker.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef DIRECT_MAPPED_CACHE_TAGS_ASSERT_SVH
`define DIRECT_MAPPED_CACHE_TAGS_ASSERT_SVH

// Same-cycle implication: when ante holds, cons holds on the same edge.
`define DMCT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dmct assertion failed");

// Next-cycle implication: when ante holds, cons holds on the next edge.
`define DMCT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dmct assertion failed");

`endif

FILE: rtl/dmct_pkg.sv
`timescale 1ns / 1ps
package dmct_pkg;

  // Configuration register map
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 6;
  localparam logic [CfgIdxW-1:0] CFG_HIT_LATENCY = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WB_PENALTY  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MISS_PENALTY = 2'd2;

  localparam int unsigned HitLatW = 4;
  localparam int unsigned PenaltyW = 6;
  localparam logic [HitLatW-1:0]  HIT_LATENCY_RST = 4'd1;
  localparam logic [PenaltyW-1:0] WB_PENALTY_RST  = 6'd5;
  localparam logic [PenaltyW-1:0] MISS_PENALTY_RST = 6'd11;

  localparam int unsigned AddrW = 32;
  localparam int unsigned CyclesW = 8;
  localparam int unsigned TotalW = 32;

  // One statistics update per finished access
  typedef struct packed {
    logic               valid;
    logic               hit;
    logic [CyclesW-1:0] cycles;
  } stat_upd_t;

endpackage

FILE: rtl/dmct_tag_ram.sv
`timescale 1ns / 1ps
module dmct_tag_ram #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned WIDTH = 30
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read: rdata_o is updated in the cycle after re_i
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: rtl/dmct_stats.sv
`timescale 1ns / 1ps
module dmct_stats (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dmct_pkg::stat_upd_t           upd_i,
  output logic [dmct_pkg::TotalW-1:0]   hits_total_o,
  output logic [dmct_pkg::TotalW-1:0]   misses_total_o,
  output logic [dmct_pkg::TotalW-1:0]   cycles_total_o
);

  logic [dmct_pkg::TotalW-1:0] hits_q, hits_d;
  logic [dmct_pkg::TotalW-1:0] misses_q, misses_d;
  logic [dmct_pkg::TotalW-1:0] cycles_q, cycles_d;
  logic [dmct_pkg::TotalW:0]   cyc_sum;

  // Hold each total at all ones once reached
  always_comb begin
    hits_d   = hits_q;
    misses_d = misses_q;
    cycles_d = cycles_q;
    cyc_sum  = {1'b0, cycles_q} + (dmct_pkg::TotalW + 1)'(upd_i.cycles);
    if (upd_i.valid) begin
      if (upd_i.hit) begin
        if (hits_q != '1) begin
          hits_d = hits_q + 1'b1;
        end
      end else begin
        if (misses_q != '1) begin
          misses_d = misses_q + 1'b1;
        end
      end
      cycles_d = cyc_sum[dmct_pkg::TotalW] ? '1 : cyc_sum[dmct_pkg::TotalW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q   <= '0;
      misses_q <= '0;
      cycles_q <= '0;
    end else begin
      hits_q   <= hits_d;
      misses_q <= misses_d;
      cycles_q <= cycles_d;
    end
  end

  assign hits_total_o   = hits_q;
  assign misses_total_o = misses_q;
  assign cycles_total_o = cycles_q;

endmodule

FILE: rtl/direct_mapped_cache_tags.sv
`timescale 1ns / 1ps
// Direct-mapped write-back cache tag controller with hit/miss/cycle statistics.
// Pulse start with an address while busy is low; the word is taken on that edge.
// Each access first reads the tag memory synchronously, then compares, updates the
// line and registers the result. The result appears on the output ports with
// done_o high for exactly one cycle, registered after the lookup state, and must
// be sampled then; it is held only until the next result. busy is low again in
// that same cycle, so a new access may start while the result is shown; busy
// stays high during the lookup. After reset the block sweeps the tag memory to
// clear valid and dirty bits, one line per cycle, so busy stays high until every
// line is cleared. Configuration writes (hit latency, write-back
// penalty, miss penalty) are taken at any edge with cfg_we_i high and should be
// issued only while no access is in flight; an unknown index is ignored.
// LINES must be a power of two; ADDR_BITS above 32 behaves as 32.
module direct_mapped_cache_tags #(
  parameter int unsigned LINES       = 4,
  parameter int unsigned OFFSET_BITS = 2,
  parameter int unsigned ADDR_BITS   = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [dmct_pkg::AddrW-1:0]        address_i,
  input  logic                              cfg_we_i,
  input  logic [dmct_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [dmct_pkg::CfgDataW-1:0]     cfg_data_i,
  output logic                              done_o,
  output logic                              hit_o,
  output logic                              writeback_o,
  output logic [dmct_pkg::CyclesW-1:0]      access_cycles_o,
  output logic [dmct_pkg::TotalW-1:0]       hits_total_o,
  output logic [dmct_pkg::TotalW-1:0]       misses_total_o,
  output logic [dmct_pkg::TotalW-1:0]       cycles_total_o
);

  localparam int unsigned IdxW    = $clog2(LINES);
  localparam int unsigned EffBits = (ADDR_BITS < dmct_pkg::AddrW) ? ADDR_BITS
                                                                  : dmct_pkg::AddrW;
  localparam int TagRaw           = int'(EffBits) - int'(OFFSET_BITS) - int'(IdxW);
  localparam int unsigned TagW    = (TagRaw > 0) ? TagRaw : 1;
  localparam int unsigned EntryW  = TagW + 2;
  localparam logic [dmct_pkg::AddrW-1:0] AddrMask =
    {dmct_pkg::AddrW{1'b1}} >> (dmct_pkg::AddrW - EffBits);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [dmct_pkg::HitLatW-1:0]  hit_lat_q;
  logic [dmct_pkg::PenaltyW-1:0] wb_pen_q;
  logic [dmct_pkg::PenaltyW-1:0] miss_pen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_lat_q  <= dmct_pkg::HIT_LATENCY_RST;
      wb_pen_q   <= dmct_pkg::WB_PENALTY_RST;
      miss_pen_q <= dmct_pkg::MISS_PENALTY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dmct_pkg::CFG_HIT_LATENCY:  hit_lat_q  <= cfg_data_i[dmct_pkg::HitLatW-1:0];
        dmct_pkg::CFG_WB_PENALTY:   wb_pen_q   <= cfg_data_i;
        dmct_pkg::CFG_MISS_PENALTY: miss_pen_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Address split: offset | index | tag, after cutting to the address width
  logic [dmct_pkg::AddrW-1:0] addr_m;
  logic [dmct_pkg::AddrW-1:0] block;
  logic [dmct_pkg::AddrW-1:0] tag_full;
  logic [IdxW-1:0]            in_idx;
  logic [TagW-1:0]            in_tag;

  assign addr_m   = address_i & AddrMask;
  assign block    = addr_m >> OFFSET_BITS;
  assign tag_full = block >> IdxW;
  assign in_idx   = block[IdxW-1:0];
  assign in_tag   = tag_full[TagW-1:0];

  logic accept;
  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  // Hold the index and tag of the access in flight
  logic [IdxW-1:0] idx_q;
  logic [TagW-1:0] tag_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q <= in_idx;
      tag_q <= in_tag;
    end
  end

  // Tag memory: {valid, dirty, tag} per line
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  logic [EntryW-1:0] ram_wdata;
  logic [EntryW-1:0] ram_rdata;

  dmct_tag_ram #(
    .DEPTH (LINES),
    .WIDTH (EntryW)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .re_i    (accept),
    .raddr_i (in_idx),
    .rdata_o (ram_rdata),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata)
  );

  // Lookup: compare the stored line against the held tag
  logic                         line_valid;
  logic                         line_dirty;
  logic [TagW-1:0]              line_tag;
  logic                         lk_hit;
  logic                         lk_wb;
  logic [dmct_pkg::CyclesW-1:0] lk_cycles;
  logic [dmct_pkg::CyclesW-1:0] miss_cycles;

  assign line_valid  = ram_rdata[EntryW-1];
  assign line_dirty  = ram_rdata[EntryW-2];
  assign line_tag    = ram_rdata[TagW-1:0];
  assign lk_hit      = line_valid && (line_tag == tag_q);
  assign lk_wb       = !lk_hit && line_valid && line_dirty;
  assign miss_cycles = dmct_pkg::CyclesW'(miss_pen_q) +
                       (lk_wb ? dmct_pkg::CyclesW'(wb_pen_q) : '0);
  assign lk_cycles   = lk_hit ? dmct_pkg::CyclesW'(hit_lat_q) : miss_cycles;

  // Clearing sweep after reset
  logic [IdxW-1:0] clr_q, clr_d;
  logic            clr_last;
  assign clr_last = (clr_q == IdxW'(LINES - 1));

  // Memory writes: zero lines during the sweep, fill the line on a miss
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = {1'b1, 1'b1, tag_q};
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      ST_LOOKUP: ram_we = !lk_hit;
      default: ;
    endcase
  end

  dmct_pkg::stat_upd_t upd;
  always_comb begin
    upd.valid  = (state_q == ST_LOOKUP);
    upd.hit    = lk_hit;
    upd.cycles = lk_cycles;
  end

  dmct_stats u_stats (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .upd_i          (upd),
    .hits_total_o   (hits_total_o),
    .misses_total_o (misses_total_o),
    .cycles_total_o (cycles_total_o)
  );

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // State, sweep counter and the registered result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_CLEAR;
      clr_q           <= '0;
      done_o          <= 1'b0;
      hit_o           <= 1'b0;
      writeback_o     <= 1'b0;
      access_cycles_o <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_o  <= (state_q == ST_LOOKUP);
      if (state_q == ST_LOOKUP) begin
        hit_o           <= lk_hit;
        writeback_o     <= lk_wb;
        access_cycles_o <= lk_cycles;
      end
    end
  end

endmodule

FILE: rtl/dmct_checker.sv
`timescale 1ns / 1ps
`include "direct_mapped_cache_tags_assert.svh"
module dmct_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic                            done_o,
  input logic                            hit_o,
  input logic                            writeback_o
);

  // A taken word occupies the block for the lookup cycle
  `DMCT_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  // Every taken word yields a result once its lookup is done
  `DMCT_ASSERT_IMP(a_accept_done, start && !busy, ##2 done_o)
  // A result only follows a busy cycle
  `DMCT_ASSERT_IMP(a_done_after_busy, done_o, $past(busy))
  // A hit never evicts
  `DMCT_ASSERT_IMP(a_hit_no_wb, done_o, !(hit_o && writeback_o))

endmodule

bind direct_mapped_cache_tags dmct_checker u_dmct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .hit_o       (hit_o),
  .writeback_o (writeback_o)
);
